// File: rtl/core/spas_pkg.sv
// ----------------------------------------------------------------------------
// spas_pkg
// Shared types and codes for the sparse polynomial add/sub/scale block.
// ----------------------------------------------------------------------------
package spas_pkg;

   typedef enum logic [2:0] {
      KIND_CLEAR  = 3'd0,
      KIND_LOAD_A = 3'd1,
      KIND_LOAD_B = 3'd2,
      KIND_ADD    = 3'd3,
      KIND_SUB    = 3'd4,
      KIND_SCALE  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_SUB   = 2'd1,
      OP_SCALE = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] factor;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_RD,
      ST_A_SCAN,
      ST_A_MUL,
      ST_A_WR,
      ST_B_RD,
      ST_B_SCAN,
      ST_B_WR,
      ST_SH_RD,
      ST_SH_CMP,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EMPTY
   } state_type;

   function automatic logic [31:0] sat33(input logic signed [32:0] v);
      logic [31:0] r;
      if (v > 33'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else if (v < -33'sh0_8000_0000) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// File: rtl/core/spas_front.sv
// ----------------------------------------------------------------------------
// spas_front
// Accepts commands, loads term lists, keeps counts and overflow flag, and
// queues compute commands for the back end.
// ----------------------------------------------------------------------------
module spas_front #(
   parameter int MAX_TERMS = 32,
   parameter int CW = $clog2(MAX_TERMS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2:0]               kind,
   input  logic [31:0]              coefficient,
   input  logic [15:0]              degree,
   input  logic [31:0]              factor,
   input  logic                     back_busy,
   output logic                     busy,
   output logic                     q_valid,
   output spas_pkg::cmd_type        q_cmd,
   input  logic                     q_pop,
   output logic                     wr_a,
   output logic                     wr_b,
   output logic [CW-1:0]            wr_idx,
   output logic [47:0]              wr_data,
   output logic [CW-1:0]            a_count,
   output logic [CW-1:0]            b_count,
   output logic                     overflow
);
   logic [CW-1:0] a_count_ff, a_count_in, b_count_ff, b_count_in;
   logic          ovf_ff, ovf_in;
   logic          qv_ff, qv_in;
   spas_pkg::cmd_type qc_ff, qc_in;
   logic          acc;

   assign busy = qv_ff | back_busy;
   assign acc  = start & ~busy;

   always_comb begin
      a_count_in = a_count_ff;
      b_count_in = b_count_ff;
      ovf_in     = ovf_ff;
      qv_in      = qv_ff & ~q_pop;
      qc_in      = qc_ff;
      wr_a       = 1'b0;
      wr_b       = 1'b0;
      wr_idx     = a_count_ff;
      if (acc) begin
         unique case (kind)
            spas_pkg::KIND_CLEAR: begin
               a_count_in = '0;
               b_count_in = '0;
               ovf_in     = 1'b0;
            end
            spas_pkg::KIND_LOAD_A: begin
               if (a_count_ff < CW'(MAX_TERMS)) begin
                  wr_a       = 1'b1;
                  a_count_in = a_count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            spas_pkg::KIND_LOAD_B: begin
               wr_idx = b_count_ff;
               if (b_count_ff < CW'(MAX_TERMS)) begin
                  wr_b       = 1'b1;
                  b_count_in = b_count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            spas_pkg::KIND_ADD: begin
               qv_in     = 1'b1;
               qc_in.op  = spas_pkg::OP_ADD;
            end
            spas_pkg::KIND_SUB: begin
               qv_in     = 1'b1;
               qc_in.op  = spas_pkg::OP_SUB;
            end
            spas_pkg::KIND_SCALE: begin
               qv_in     = 1'b1;
               qc_in.op  = spas_pkg::OP_SCALE;
               qc_in.factor = factor;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_count_ff <= '0;
         b_count_ff <= '0;
         ovf_ff     <= 1'b0;
         qv_ff      <= 1'b0;
      end else begin
         a_count_ff <= a_count_in;
         b_count_ff <= b_count_in;
         ovf_ff     <= ovf_in;
         qv_ff      <= qv_in;
      end
      qc_ff <= qc_in;
   end

   assign wr_data  = {coefficient, degree};
   assign q_valid  = qv_ff;
   assign q_cmd    = qc_ff;
   assign a_count  = a_count_ff;
   assign b_count  = b_count_ff;
   assign overflow = ovf_ff;
endmodule

// File: rtl/core/spas_back.sv
// ----------------------------------------------------------------------------
// spas_back
// Term stores and the sequencer that combines, scales, sorts on insert and
// streams out the result.
// ----------------------------------------------------------------------------
module spas_back #(
   parameter int MAX_TERMS = 32,
   parameter int CW = $clog2(MAX_TERMS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_a,
   input  logic                     wr_b,
   input  logic [CW-1:0]            wr_idx,
   input  logic [47:0]              wr_data,
   input  logic [CW-1:0]            a_count,
   input  logic [CW-1:0]            b_count,
   input  logic                     overflow,
   input  logic                     q_valid,
   input  spas_pkg::cmd_type        q_cmd,
   output logic                     q_pop,
   output logic                     back_busy,
   output logic                     out_valid,
   output logic [31:0]              out_coef,
   output logic [15:0]              out_deg,
   output logic                     out_last,
   output logic                     out_empty,
   output logic                     out_dropped
);
   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int RD = 2 * MAX_TERMS;
   localparam int RW = $clog2(RD + 1);
   localparam int RA = $clog2(RD);

   logic [47:0] a_mem [MAX_TERMS];
   logic [47:0] b_mem [MAX_TERMS];
   logic [47:0] a_rd, b_rd;
   logic [AW-1:0] a_ra, b_ra;

   // result kept sorted by insertion: ascending degree, stable
   logic [47:0]   r_mem [RD];
   logic [47:0]   r_rd;
   logic [47:0]   r_wd;
   logic [RA-1:0] r_ra, r_wa;
   logic          r_we;
   logic [RW-1:0] n_ff, n_in;
   logic [RW-1:0] p_ff, p_in, p_dec;

   spas_pkg::state_type st_ff, st_in, ret_ff, ret_in, after_a, after_b;
   spas_pkg::cmd_type   cmd_ff;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic          hit_ff, hit_in;
   logic [31:0]   bc_ff, bc_in;
   logic [47:0]   cur_ff;
   logic [47:0]   ins_ff, ins_in;
   logic signed [63:0] prod_ff;
   logic [RW-1:0] e_ff, e_in, e_inc;
   logic          a_last, b_last;
   logic [47:0]   ins_data;
   logic signed [63:0] p;
   logic signed [47:0] q;

   always_ff @(posedge clock) begin
      if (wr_a) a_mem[wr_idx[AW-1:0]] <= wr_data;
      if (wr_b) b_mem[wr_idx[AW-1:0]] <= wr_data;
      a_rd <= a_mem[a_ra];
      b_rd <= b_mem[b_ra];
   end

   always_ff @(posedge clock) begin
      if (r_we) r_mem[r_wa] <= r_wd;
      r_rd <= r_mem[r_ra];
   end

   assign a_ra   = i_ff[AW-1:0];
   assign b_ra   = j_ff[AW-1:0];
   assign p_dec  = p_ff - 1'b1;
   assign e_inc  = e_ff + 1'b1;
   assign a_last = (i_ff + 1'b1 == a_count);
   assign b_last = (j_ff + 1'b1 == b_count);

   assign after_a = !a_last ? spas_pkg::ST_A_RD :
                    (cmd_ff.op == spas_pkg::OP_SCALE || b_count == '0) ?
                    spas_pkg::ST_EMIT_RD : spas_pkg::ST_B_RD;
   assign after_b = !b_last ? spas_pkg::ST_B_RD : spas_pkg::ST_EMIT_RD;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         spas_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (a_count != '0) st_in = spas_pkg::ST_A_RD;
               else if (q_cmd.op == spas_pkg::OP_SCALE || b_count == '0)
                  st_in = spas_pkg::ST_EMPTY;
               else st_in = spas_pkg::ST_B_RD;
            end
         end
         spas_pkg::ST_A_RD: begin
            st_in = (cmd_ff.op == spas_pkg::OP_SCALE) ? spas_pkg::ST_A_MUL :
                    spas_pkg::ST_A_SCAN;
         end
         spas_pkg::ST_A_SCAN: begin
            if (j_ff == b_count) st_in = spas_pkg::ST_A_WR;
         end
         spas_pkg::ST_A_MUL: st_in = spas_pkg::ST_A_WR;
         spas_pkg::ST_A_WR: st_in = spas_pkg::ST_SH_RD;
         spas_pkg::ST_B_RD: st_in = spas_pkg::ST_B_SCAN;
         spas_pkg::ST_B_SCAN: begin
            if (i_ff == a_count) st_in = spas_pkg::ST_B_WR;
         end
         spas_pkg::ST_B_WR: begin
            st_in = hit_ff ? after_b : spas_pkg::ST_SH_RD;
         end
         spas_pkg::ST_SH_RD: begin
            if (p_ff == '0) st_in = ret_ff;
            else st_in = spas_pkg::ST_SH_CMP;
         end
         spas_pkg::ST_SH_CMP: begin
            if (r_rd[15:0] > ins_ff[15:0]) st_in = spas_pkg::ST_SH_RD;
            else st_in = ret_ff;
         end
         spas_pkg::ST_EMIT_RD: st_in = spas_pkg::ST_EMIT_OUT;
         spas_pkg::ST_EMIT_OUT: begin
            if (e_inc == n_ff) st_in = spas_pkg::ST_IDLE;
         end
         spas_pkg::ST_EMPTY: st_in = spas_pkg::ST_IDLE;
         default: st_in = spas_pkg::ST_IDLE;
      endcase
   end

   // sequencer datapath and controls
   always_comb begin
      i_in   = i_ff;
      j_in   = j_ff;
      hit_in = hit_ff;
      bc_in  = bc_ff;
      n_in   = n_ff;
      e_in   = e_ff;
      p_in   = p_ff;
      ins_in = ins_ff;
      ret_in = ret_ff;
      q_pop  = 1'b0;
      r_we   = 1'b0;
      r_wa   = p_ff[RA-1:0];
      r_wd   = ins_ff;
      r_ra   = p_dec[RA-1:0];
      unique case (st_ff)
         spas_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               i_in  = '0;
               j_in  = '0;
               n_in  = '0;
            end
         end
         spas_pkg::ST_A_RD: begin
            j_in   = '0;
            hit_in = 1'b0;
         end
         spas_pkg::ST_A_SCAN: begin
            // b_rd holds entry j-1 whenever j is nonzero
            if (j_ff != '0 && b_rd[15:0] == cur_ff[15:0]) begin
               hit_in = 1'b1;
               bc_in  = b_rd[47:16];
            end
            if (j_ff != b_count) j_in = j_ff + 1'b1;
         end
         spas_pkg::ST_A_WR: begin
            ins_in = ins_data;
            p_in   = n_ff;
            ret_in = after_a;
            i_in   = i_ff + 1'b1;
            j_in   = '0;
         end
         spas_pkg::ST_B_RD: begin
            i_in   = '0;
            hit_in = 1'b0;
         end
         spas_pkg::ST_B_SCAN: begin
            if (i_ff != '0 && a_rd[15:0] == cur_ff[15:0]) hit_in = 1'b1;
            if (i_ff != a_count) i_in = i_ff + 1'b1;
         end
         spas_pkg::ST_B_WR: begin
            ins_in = ins_data;
            p_in   = n_ff;
            ret_in = after_b;
            j_in   = j_ff + 1'b1;
         end
         spas_pkg::ST_SH_RD: begin
            if (p_ff == '0) begin
               r_we = 1'b1;
               n_in = n_ff + 1'b1;
            end
         end
         spas_pkg::ST_SH_CMP: begin
            // move the larger entry up one slot, or drop the new term here
            r_we = 1'b1;
            if (r_rd[15:0] > ins_ff[15:0]) begin
               r_wd = r_rd;
               p_in = p_dec;
            end else begin
               n_in = n_ff + 1'b1;
            end
         end
         spas_pkg::ST_EMIT_RD: begin
            e_in = '0;
            r_ra = '0;
         end
         spas_pkg::ST_EMIT_OUT: begin
            e_in = e_inc;
            r_ra = e_inc[RA-1:0];
         end
         default: ;
      endcase
   end

   // coefficient to insert
   always_comb begin
      p = prod_ff + 64'sh8000;
      q = 48'(p >>> 16);
      ins_data = {a_rd[47:16], cur_ff[15:0]};
      if (st_ff == spas_pkg::ST_A_WR) begin
         if (cmd_ff.op == spas_pkg::OP_SCALE) begin
            if (q > 48'sh0000_7FFF_FFFF) ins_data[47:16] = 32'h7FFF_FFFF;
            else if (q < -48'sh0000_8000_0000) ins_data[47:16] = 32'h8000_0000;
            else ins_data[47:16] = q[31:0];
         end else if (hit_ff) begin
            if (cmd_ff.op == spas_pkg::OP_SUB)
               ins_data[47:16] = spas_pkg::sat33({cur_ff[47], cur_ff[47:16]}
                                                 - {bc_ff[31], bc_ff});
            else
               ins_data[47:16] = spas_pkg::sat33({cur_ff[47], cur_ff[47:16]}
                                                 + {bc_ff[31], bc_ff});
         end else begin
            ins_data[47:16] = cur_ff[47:16];
         end
      end else begin
         if (cmd_ff.op == spas_pkg::OP_SUB)
            ins_data[47:16] = spas_pkg::sat33(33'sd0 - {cur_ff[47], cur_ff[47:16]});
         else
            ins_data[47:16] = cur_ff[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= spas_pkg::ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      hit_ff <= hit_in;
      bc_ff  <= bc_in;
      n_ff   <= n_in;
      e_ff   <= e_in;
      p_ff   <= p_in;
      ins_ff <= ins_in;
      ret_ff <= ret_in;
      if (st_ff == spas_pkg::ST_IDLE && q_valid) cmd_ff <= q_cmd;
      if (st_ff == spas_pkg::ST_A_SCAN && j_ff == '0) cur_ff <= a_rd;
      if (st_ff == spas_pkg::ST_A_MUL) cur_ff <= a_rd;
      if (st_ff == spas_pkg::ST_B_SCAN && i_ff == '0) cur_ff <= b_rd;
      prod_ff <= $signed(a_rd[47:16]) * $signed(cmd_ff.factor);
   end

   assign back_busy   = (st_ff != spas_pkg::ST_IDLE);
   assign out_valid   = (st_ff == spas_pkg::ST_EMIT_OUT) || (st_ff == spas_pkg::ST_EMPTY);
   assign out_empty   = (st_ff == spas_pkg::ST_EMPTY);
   assign out_coef    = out_empty ? 32'h0 : r_rd[47:16];
   assign out_deg     = out_empty ? 16'h0 : r_rd[15:0];
   assign out_last    = out_empty || (e_inc == n_ff);
   assign out_dropped = overflow;
endmodule

// File: rtl/core/sparse_polynomial_add_sub_scale_top.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_add_sub_scale_top
// Loads and clear are accepted one per cycle while busy is low.
// Add/sub: each stored term is placed by shifting larger-degree terms up,
// then one term per cycle is streamed out; busy until the last.
// Scale: each A term is scaled and stored the same way, then one term per cycle.
// Receiver cannot stall. Reset is synchronous, clears counts and flag.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_sub_scale_top #(
   parameter int MAX_TERMS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic signed [31:0] req_coefficient,
   input  logic [15:0] req_degree,
   input  logic signed [31:0] req_factor,
   output logic        rsp_strobe,
   output logic signed [31:0] rsp_term_coefficient,
   output logic [15:0] rsp_term_degree,
   output logic        rsp_last,
   output logic        rsp_empty_res,
   output logic        rsp_dropped
);
   localparam int CW = $clog2(MAX_TERMS + 1);
   logic q_valid, q_pop, back_busy, wr_a, wr_b, overflow;
   spas_pkg::cmd_type q_cmd;
   logic [CW-1:0] wr_idx, a_count, b_count;
   logic [47:0] wr_data;

   spas_front #(.MAX_TERMS(MAX_TERMS), .CW(CW)) u_front (
      .clock, .reset, .start, .kind(req_kind), .coefficient(req_coefficient),
      .degree(req_degree), .factor(req_factor), .back_busy, .busy,
      .q_valid, .q_cmd, .q_pop, .wr_a, .wr_b, .wr_idx, .wr_data,
      .a_count, .b_count, .overflow);

   spas_back #(.MAX_TERMS(MAX_TERMS), .CW(CW)) u_back (
      .clock, .reset, .wr_a, .wr_b, .wr_idx, .wr_data, .a_count, .b_count,
      .overflow, .q_valid, .q_cmd, .q_pop, .back_busy,
      .out_valid(rsp_strobe), .out_coef(rsp_term_coefficient),
      .out_deg(rsp_term_degree), .out_last(rsp_last),
      .out_empty(rsp_empty_res), .out_dropped(rsp_dropped));

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_empty_res |-> rsp_last) else $error("empty without last");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result while idle");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      a_count <= CW'(MAX_TERMS) && b_count <= CW'(MAX_TERMS)) else $error("count range");
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sparse polynomial add/sub/scale block: polynomials are loaded
// term by term, combined or scaled, and every result term is compared with
// a behavioral predictor, under several sender idling phases.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CAP = 32;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] coefficient;
      logic [15:0] degree;
      logic [31:0] factor;
      int          idle_pct;
   } word_type;

   typedef struct {
      logic [31:0] coefficient;
      logic [15:0] degree;
      logic        last;
      logic        empty_res;
      logic        dropped;
   } term_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_kind = '0;
   logic [31:0] req_coefficient = '0;
   logic [15:0] req_degree = '0;
   logic [31:0] req_factor = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_term_coefficient;
   logic [15:0] rsp_term_degree;
   logic        rsp_last, rsp_empty_res, rsp_dropped;

   word_type pending_words[$];
   term_type expected_terms[$];
   int    mismatches = 0;
   int    terms_seen = 0;
   int    words_sent = 0;
   int    ops_sent = 0;
   bit    stim_done = 0;
   int    idles[4] = '{0, 54, 0, 31};

   logic signed [31:0] a_coef[CAP];
   logic [15:0]        a_deg[CAP];
   logic signed [31:0] b_coef[CAP];
   logic [15:0]        b_deg[CAP];
   int                 a_cnt = 0, b_cnt = 0;
   bit                 ovf = 0;

   sparse_polynomial_add_sub_scale_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_coefficient(req_coefficient),
      .req_degree(req_degree), .req_factor(req_factor),
      .rsp_strobe(rsp_strobe), .rsp_term_coefficient(rsp_term_coefficient),
      .rsp_term_degree(rsp_term_degree), .rsp_last(rsp_last),
      .rsp_empty_res(rsp_empty_res), .rsp_dropped(rsp_dropped)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic logic [31:0] clamp32(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -66'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [31:0] q16_product(input logic signed [31:0] a,
                                               input logic signed [31:0] f);
      logic signed [65:0] p;
      p = $signed({{34{a[31]}}, a}) * $signed({{34{f[31]}}, f}) + 66'sd32768;
      return clamp32(p >>> 16);
   endfunction

   task automatic predict_word(input word_type w);
      logic [31:0] rc[$];
      logic [15:0] rd[$];
      logic signed [65:0] s;
      logic [31:0] c, tc;
      logic [15:0] td;
      term_type t;
      bit found;
      int j;
      case (w.kind) inside
         spas_pkg::KIND_CLEAR: begin
            a_cnt = 0; b_cnt = 0; ovf = 0;
         end
         spas_pkg::KIND_LOAD_A: begin
            if (a_cnt < CAP) begin
               a_coef[a_cnt] = w.coefficient; a_deg[a_cnt] = w.degree; a_cnt++;
            end else ovf = 1;
         end
         spas_pkg::KIND_LOAD_B: begin
            if (b_cnt < CAP) begin
               b_coef[b_cnt] = w.coefficient; b_deg[b_cnt] = w.degree; b_cnt++;
            end else ovf = 1;
         end
         spas_pkg::KIND_ADD, spas_pkg::KIND_SUB, spas_pkg::KIND_SCALE: begin
            for (int i = 0; i < a_cnt; i++) begin
               c = a_coef[i];
               if (w.kind == spas_pkg::KIND_SCALE) c = q16_product(a_coef[i], w.factor);
               else
                  for (int k = 0; k < b_cnt; k++)
                     if (b_deg[k] == a_deg[i]) begin
                        s = (w.kind == spas_pkg::KIND_SUB) ?
                            66'(a_coef[i]) - 66'(b_coef[k]) :
                            66'(a_coef[i]) + 66'(b_coef[k]);
                        c = clamp32(s);
                     end
               rc.push_back(c); rd.push_back(a_deg[i]);
            end
            if (w.kind != spas_pkg::KIND_SCALE)
               for (int k = 0; k < b_cnt; k++) begin
                  found = 0;
                  for (int i = 0; i < a_cnt; i++)
                     if (a_deg[i] == b_deg[k]) found = 1;
                  if (!found) begin
                     s = (w.kind == spas_pkg::KIND_SUB) ? -66'(b_coef[k]) : 66'(b_coef[k]);
                     rc.push_back(clamp32(s)); rd.push_back(b_deg[k]);
                  end
               end
            for (int i = 1; i < rc.size(); i++) begin
               tc = rc[i]; td = rd[i]; j = i;
               while (j > 0 && rd[j-1] > td) begin
                  rc[j] = rc[j-1]; rd[j] = rd[j-1]; j--;
               end
               rc[j] = tc; rd[j] = td;
            end
            if (rc.size() == 0) begin
               t = '{32'd0, 16'd0, 1'b1, 1'b1, ovf};
               expected_terms.push_back(t);
            end
            for (int i = 0; i < rc.size(); i++) begin
               t = '{rc[i], rd[i], i == rc.size() - 1, 1'b0, ovf};
               expected_terms.push_back(t);
            end
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (!(start && busy)) begin
         if (start) begin
            words_sent++;
            predict_word('{req_kind, req_coefficient, req_degree, req_factor, 0});
         end
         if (pending_words.size() > 0 &&
             $urandom_range(99, 0) >= pending_words[0].idle_pct) begin
            word_type w;
            w = pending_words.pop_front();
            start <= 1;
            req_kind <= w.kind;
            req_coefficient <= w.coefficient;
            req_degree <= w.degree;
            req_factor <= w.factor;
         end else begin
            start <= 0;
            req_kind <= 3'($urandom);
            req_coefficient <= $urandom;
            req_degree <= 16'($urandom);
            req_factor <= $urandom;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         term_type e;
         terms_seen++;
         if (expected_terms.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected term coef=%h deg=%0d", rsp_term_coefficient,
                        rsp_term_degree);
         end else begin
            e = expected_terms.pop_front();
            if (e.coefficient !== rsp_term_coefficient || e.degree !== rsp_term_degree
                || e.last !== rsp_last || e.empty_res !== rsp_empty_res
                || e.dropped !== rsp_dropped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch exp coef=%h deg=%0d last=%b empty=%b drop=%b",
                            " / got coef=%h deg=%0d last=%b empty=%b drop=%b"},
                           e.coefficient, e.degree, e.last, e.empty_res, e.dropped,
                           rsp_term_coefficient, rsp_term_degree, rsp_last,
                           rsp_empty_res, rsp_dropped);
            end
         end
      end
   end

   task automatic push_word(input logic [2:0] k, input logic [31:0] c,
                            input logic [15:0] d, input logic [31:0] f,
                            input int idle);
      pending_words.push_back('{k, c, d, f, idle});
      if (k >= spas_pkg::KIND_ADD && k <= spas_pkg::KIND_SCALE) ops_sent++;
   endtask

   task automatic random_poly_op(input int idle);
      int na, nb, span;
      logic [2:0] op;
      logic [31:0] c;
      na = ($urandom_range(9, 0) == 0) ? $urandom_range(34, 30) : $urandom_range(6, 0);
      nb = ($urandom_range(9, 0) == 0) ? $urandom_range(34, 30) : $urandom_range(6, 0);
      span = ($urandom_range(3, 0) == 0) ? 65535 : 8;
      push_word(spas_pkg::KIND_CLEAR, $urandom, 16'($urandom), $urandom, idle);
      for (int i = 0; i < na; i++) begin
         c = ($urandom_range(3, 0) == 0) ?
             (32'h8000_0000 | $urandom_range(1, 0) * 32'h7FFF_FFFF) : $urandom;
         push_word(spas_pkg::KIND_LOAD_A, c, 16'($urandom_range(span, 0)), $urandom,
                   idle);
      end
      for (int i = 0; i < nb; i++)
         push_word(spas_pkg::KIND_LOAD_B, $urandom, 16'($urandom_range(span, 0)),
                   $urandom, idle);
      for (int r = $urandom_range(2, 1); r > 0; r--) begin
         op = 3'($urandom_range(spas_pkg::KIND_SCALE, spas_pkg::KIND_ADD));
         if ($urandom_range(9, 0) == 0) op = 3'($urandom_range(7, 6));
         push_word(op, $urandom, 16'($urandom), $urandom, idle);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed
      push_word(spas_pkg::KIND_ADD, 0, 0, 0, 0);
      push_word(spas_pkg::KIND_SCALE, 0, 0, 32'h0001_0000, 0);
      push_word(spas_pkg::KIND_LOAD_A, 32'h7FFF_FFFF, 16'd5, 0, 0);
      push_word(spas_pkg::KIND_LOAD_A, 32'h8000_0000, 16'hFFFF, 0, 0);
      push_word(spas_pkg::KIND_LOAD_A, 32'h0001_8000, 16'd0, 0, 0);
      push_word(spas_pkg::KIND_LOAD_B, 32'h0000_0001, 16'd5, 0, 0);
      push_word(spas_pkg::KIND_LOAD_B, 32'h0000_0002, 16'd5, 0, 0);
      push_word(spas_pkg::KIND_LOAD_B, 32'h8000_0000, 16'd7, 0, 0);
      push_word(spas_pkg::KIND_LOAD_B, 32'h0000_0001, 16'hFFFF, 0, 0);
      push_word(spas_pkg::KIND_ADD, 0, 0, 0, 0);
      push_word(spas_pkg::KIND_SUB, 0, 0, 0, 0);
      push_word(spas_pkg::KIND_SCALE, 0, 0, 32'h7FFF_FFFF, 0);
      push_word(spas_pkg::KIND_SCALE, 0, 0, 32'h8000_0000, 0);
      push_word(spas_pkg::KIND_SCALE, 0, 0, 32'hFFFF_8000, 0);
      push_word(3'd6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
      push_word(3'd7, 0, 0, 0, 0);
      push_word(spas_pkg::KIND_CLEAR, 0, 0, 0, 0);
      push_word(spas_pkg::KIND_LOAD_B, 32'h0000_0003, 16'd2, 0, 0);
      push_word(spas_pkg::KIND_SUB, 0, 0, 0, 0);
      for (int i = 0; i < 33; i++)
         push_word(spas_pkg::KIND_LOAD_A, $urandom, 16'(i % 3), 0, 0);
      push_word(spas_pkg::KIND_SCALE, 0, 0, 32'h0000_8000, 0);
      push_word(spas_pkg::KIND_CLEAR, 0, 0, 0, 0);
      push_word(spas_pkg::KIND_ADD, 0, 0, 0, 0);
      // random, in idling phases
      for (int p = 0; p < 4; p++)
         while (words_sent + pending_words.size() < 50 + 53 * (p + 1))
            random_poly_op(idles[p]);
      wait (pending_words.size() == 0 && !start);
      wait (expected_terms.size() == 0);
      repeat (50) @(posedge clock);
      $display("sent %0d words (%0d operations), checked %0d result terms",
               words_sent, ops_sent, terms_seen);
      if (mismatches == 0 && expected_terms.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #100ms;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/spas_pkg.sv
rtl/core/spas_front.sv
rtl/core/spas_back.sv
rtl/core/sparse_polynomial_add_sub_scale_top.sv
tb/sv/testbench.sv
